// ===== src/bba_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg
// shared types and constants for the bitmap block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MAP_BITS  = 65536;
    localparam int WORD_W    = 32;
    localparam int WORDS     = MAP_BITS / WORD_W;
    localparam int WADDR_W   = $clog2(WORDS);
    localparam int GRP_W     = 32;
    localparam int GROUPS    = WORDS / GRP_W;
    localparam int GADDR_W   = $clog2(GROUPS);
    localparam int LIM_W     = 17;
    localparam int ID_W      = 16;
    localparam int QDEPTH    = 2;

    localparam logic [LIM_W-1:0] LIM_RESET = 17'd65534;
    localparam logic [LIM_W-1:0] LIM_MAX   = 17'd65536;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_REQUEST = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_TEST    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_CONFLICT = 2'd3
    } t_status;

    // classified request from front to back
    typedef struct packed {
        t_cmd            cmd;
        logic            in_range;
        logic [ID_W-1:0] id;
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_SUM_RD,
        S_SUM_CHK,
        S_MAP_RD,
        S_MAP_CHK,
        S_WRITE,
        S_DONE
    } t_state;

    function automatic logic [4:0] first_zero(input logic [WORD_W-1:0] w);
        logic [4:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w[i]) r = 5'(i);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/bitmap_block_allocator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// first-fit free block allocator over a 64k-bit in-use map
// ----------------------------------------------------------------------------
// A request is allocate, claim, release or test; each gives one response with
// the used and free counts. The front end range checks requests into a two
// entry queue; the back end works them against a 2048 x 32 map ram and a
// 64 x 32 summary ram whose bits mark full map words. Claim, release and test
// read, check and write back one map word; allocate first scans the summary
// ram a word at a time (at most 64 words) for a map word that is not full.
// After reset a clearing pass over all 2048 map words zeroes both rams
// before the first request is worked; the config port stays open throughout.
module bitmap_block_allocator_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [16:0] i_cfg_usable_blocks,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [1:0]  i_cmd,
    input  wire  [15:0] i_block_id,
    output logic        o_valid,
    input  wire         i_ready,
    output logic        o_success,
    output logic [1:0]  o_status,
    output logic [15:0] o_granted_id,
    output logic [16:0] o_used_count,
    output logic [16:0] o_free_count
);
    logic [16:0]   r_usable;
    logic [16:0]   lim;
    logic          q_valid, q_pop;
    bba_pkg::t_req q_req;

    assign o_cfg_ready = 1'b1;

    // usable count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_usable <= bba_pkg::LIM_RESET;
        end else if (i_cfg_valid) begin
            r_usable <= i_cfg_usable_blocks;
        end
    end

    // limit saturated to the map size
    assign lim = (r_usable > bba_pkg::LIM_MAX) ? bba_pkg::LIM_MAX : r_usable;

    bba_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_cmd(i_cmd), .i_block_id(i_block_id), .i_lim(lim),
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_req(q_req));

    bba_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_lim(lim),
        .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_req(q_req),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_success(o_success), .o_status(o_status),
        .o_granted_id(o_granted_id), .o_used_count(o_used_count),
        .o_free_count(o_free_count));
endmodule
`default_nettype wire

// ===== src/bba_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_addr,
    input  wire  [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== src/bba_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bba_front
// accepts requests, checks range and queues them for the back end
// ----------------------------------------------------------------------------
module bba_front (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_ready,
    input  wire  [1:0]                i_cmd,
    input  wire  [bba_pkg::ID_W-1:0]  i_block_id,
    input  wire  [bba_pkg::LIM_W-1:0] i_lim,
    output logic                      o_q_valid,
    input  wire                       i_q_pop,
    output bba_pkg::t_req             o_q_req
);
    bba_pkg::t_req r_q [bba_pkg::QDEPTH];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       push;
    bba_pkg::t_req in_req;

    assign o_ready   = (r_cnt != 2'(bba_pkg::QDEPTH));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_req   = r_q[0];

    always_comb begin
        in_req.cmd      = bba_pkg::t_cmd'(i_cmd);
        in_req.id       = i_block_id;
        in_req.in_range = ({1'b0, i_block_id} < i_lim);
        n_cnt = r_cnt + 2'(push) - 2'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // two entry shift queue, head at index zero
    always_ff @(posedge i_clk) begin
        if (i_q_pop) begin
            if (push && r_cnt == 2'd1) r_q[0] <= in_req;
            else r_q[0] <= r_q[1];
        end else if (push && r_cnt == 2'd0) begin
            r_q[0] <= in_req;
        end
        if (push && !i_q_pop && r_cnt == 2'd1) begin
            r_q[1] <= in_req;
        end
    end
endmodule
`default_nettype wire

// ===== src/bba_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bba_back
// executes requests against the map and its full-word summary
// ----------------------------------------------------------------------------
module bba_back (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire  [bba_pkg::LIM_W-1:0] i_lim,
    input  wire                       i_q_valid,
    output logic                      o_q_pop,
    input  wire  bba_pkg::t_req       i_q_req,
    output logic                      o_valid,
    input  wire                       i_ready,
    output logic                      o_success,
    output logic [1:0]                o_status,
    output logic [bba_pkg::ID_W-1:0]  o_granted_id,
    output logic [bba_pkg::LIM_W-1:0] o_used_count,
    output logic [bba_pkg::LIM_W-1:0] o_free_count
);
    localparam int WA = bba_pkg::WADDR_W;
    localparam int GA = bba_pkg::GADDR_W;

    bba_pkg::t_state r_state, n_state;
    logic [WA-1:0] r_ptr, n_ptr;
    logic [GA-1:0] r_grp, n_grp;
    logic [bba_pkg::LIM_W-1:0] r_used, n_used;
    logic [31:0] r_word, n_word;
    bba_pkg::t_req r_req;
    logic r_out_v;

    logic          m_we, s_we;
    logic [WA-1:0] m_addr;
    logic [GA-1:0] s_addr;
    logic [31:0]   m_wdata, s_wdata, m_rdata, s_rdata;

    logic r_suc, n_suc;
    logic [1:0] r_st, n_st;
    logic [bba_pkg::ID_W-1:0] r_gid, n_gid;
    logic [4:0] bitpos;
    logic [bba_pkg::LIM_W-1:0] cand;
    logic       load;

    bba_ram #(.WIDTH(32), .DEPTH(bba_pkg::WORDS)) u_map (
        .i_clk(i_clk), .i_we(m_we), .i_addr(m_addr),
        .i_wdata(m_wdata), .o_rdata(m_rdata));
    bba_ram #(.WIDTH(32), .DEPTH(bba_pkg::GROUPS)) u_sum (
        .i_clk(i_clk), .i_we(s_we), .i_addr(s_addr),
        .i_wdata(s_wdata), .o_rdata(s_rdata));

    assign load = (r_state == bba_pkg::S_IDLE) && i_q_valid && !r_out_v;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bba_pkg::S_CLEAR: if (&r_ptr) n_state = bba_pkg::S_IDLE;
            bba_pkg::S_IDLE: if (load) begin
                if (i_q_req.cmd == bba_pkg::CMD_ALLOC) n_state = bba_pkg::S_SUM_RD;
                else if (!i_q_req.in_range) n_state = bba_pkg::S_DONE;
                else n_state = bba_pkg::S_MAP_RD;
            end
            bba_pkg::S_SUM_RD:  n_state = bba_pkg::S_SUM_CHK;
            bba_pkg::S_SUM_CHK: begin
                if (&s_rdata || {r_grp, 10'd0} >= i_lim) begin
                    if (&r_grp || {r_grp, 10'd0} >= i_lim) n_state = bba_pkg::S_DONE;
                    else n_state = bba_pkg::S_SUM_RD;
                end else begin
                    n_state = bba_pkg::S_MAP_RD;
                end
            end
            bba_pkg::S_MAP_RD:  n_state = bba_pkg::S_MAP_CHK;
            bba_pkg::S_MAP_CHK: n_state = bba_pkg::S_WRITE;
            bba_pkg::S_WRITE:   n_state = bba_pkg::S_DONE;
            bba_pkg::S_DONE:    n_state = bba_pkg::S_IDLE;
            default:            n_state = bba_pkg::S_IDLE;
        endcase
    end

    assign bitpos = bba_pkg::first_zero(m_rdata);
    assign cand   = {1'b0, r_ptr, bitpos};

    // datapath and memory control
    always_comb begin
        n_ptr = r_ptr; n_grp = r_grp; n_used = r_used; n_word = r_word;
        n_suc = r_suc; n_st = r_st; n_gid = r_gid;
        m_we = 1'b0; s_we = 1'b0;
        m_addr = r_ptr; s_addr = r_grp;
        m_wdata = '0; s_wdata = '0;
        o_q_pop = 1'b0;
        unique case (r_state)
            bba_pkg::S_CLEAR: begin
                m_we = 1'b1; s_we = 1'b1;
                s_addr = r_ptr[GA-1:0];
                n_ptr = r_ptr + 1'b1;
            end
            bba_pkg::S_IDLE: if (load) begin
                o_q_pop = 1'b1;
                n_suc = 1'b0; n_st = bba_pkg::ST_OK; n_gid = '0;
                n_grp = '0;
                n_ptr = i_q_req.id[bba_pkg::ID_W-1:5];
                if (i_q_req.cmd != bba_pkg::CMD_ALLOC && !i_q_req.in_range)
                    n_st = bba_pkg::ST_RANGE;
            end
            bba_pkg::S_SUM_RD: s_addr = r_grp;
            bba_pkg::S_SUM_CHK: begin
                if (&s_rdata || {r_grp, 10'd0} >= i_lim) begin
                    n_grp = r_grp + 1'b1;
                    if (&r_grp || {r_grp, 10'd0} >= i_lim) n_st = bba_pkg::ST_FULL;
                end else begin
                    n_ptr = {r_grp, bba_pkg::first_zero(s_rdata)};
                end
            end
            bba_pkg::S_MAP_RD: m_addr = r_ptr;
            bba_pkg::S_MAP_CHK: begin
                n_word = m_rdata;
                unique case (r_req.cmd)
                    bba_pkg::CMD_ALLOC: begin
                        // first free bit of the word is granted below limit; a candidate at or past limit means full
                        if (cand < i_lim) begin
                            n_suc = 1'b1; n_gid = cand[bba_pkg::ID_W-1:0];
                            n_word[bitpos] = 1'b1; n_used = r_used + 1'b1;
                        end else begin
                            n_st = bba_pkg::ST_FULL;
                        end
                    end
                    bba_pkg::CMD_REQUEST: begin
                        if (m_rdata[r_req.id[4:0]]) n_st = bba_pkg::ST_CONFLICT;
                        else begin
                            n_suc = 1'b1; n_word[r_req.id[4:0]] = 1'b1;
                            n_used = r_used + 1'b1;
                        end
                    end
                    bba_pkg::CMD_RELEASE: begin
                        if (!m_rdata[r_req.id[4:0]]) n_st = bba_pkg::ST_CONFLICT;
                        else begin
                            n_suc = 1'b1; n_word[r_req.id[4:0]] = 1'b0;
                            n_used = r_used - 1'b1;
                        end
                    end
                    bba_pkg::CMD_TEST: n_suc = m_rdata[r_req.id[4:0]];
                    default: ;
                endcase
                s_addr = r_ptr[WA-1:5];
            end
            bba_pkg::S_WRITE: begin
                m_we = 1'b1; m_wdata = r_word;
                s_addr = r_ptr[WA-1:5];
                s_we = 1'b1;
                s_wdata = s_rdata;
                s_wdata[r_ptr[4:0]] = &r_word;
            end
            bba_pkg::S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::S_CLEAR;
            r_ptr   <= '0;
            r_used  <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_used  <= n_used;
            if (r_state == bba_pkg::S_DONE) r_out_v <= 1'b1;
            else if (i_ready) r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp; r_word <= n_word;
        r_suc <= n_suc; r_st <= n_st; r_gid <= n_gid;
        if (load) r_req <= i_q_req;
        if (r_state == bba_pkg::S_DONE) begin
            o_success    <= r_suc;
            o_status     <= r_st;
            o_granted_id <= r_gid;
            o_used_count <= r_used;
            o_free_count <= (i_lim > r_used) ? i_lim - r_used : '0;
        end
    end

    assign o_valid = r_out_v;
endmodule
`default_nettype wire
